@@ sv/speed_pi_controller_q22_10_defines.svh @@
// Assertion macros shared by the speed PI controller RTL.
`ifndef SPEED_PI_CONTROLLER_Q22_10_DEFINES_SVH
`define SPEED_PI_CONTROLLER_Q22_10_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ sv/spc_pkg.sv @@
// Package with widths, register codes, reset values and shared types of the PI controller.
`timescale 1ns / 1ps
package spc_pkg;

  localparam int ACC_WIDTH      = 32;
  localparam int GAIN_WIDTH     = 16;
  localparam int PROD_WIDTH     = ACC_WIDTH + GAIN_WIDTH + 1;
  localparam int FRAC_BITS      = 10;
  localparam int SPEED_WIDTH    = 16;
  localparam int ERR_WIDTH      = SPEED_WIDTH + 1;
  localparam int DUTY_WIDTH     = 16;
  localparam int DUTY_LIM_WIDTH = 15;
  localparam int DUTY_SHIFT     = 2;
  localparam int ADDR_WIDTH     = 5;
  localparam int DATA_WIDTH     = 32;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_DUTY_UPPER    = 3'd3,
    REG_DUTY_LOWER    = 3'd4
  } reg_idx_t;

  localparam logic [GAIN_WIDTH-1:0]     PROP_GAIN_RST     = 16'd10;
  localparam logic [GAIN_WIDTH-1:0]     INTEGRAL_GAIN_RST = 16'd512;
  localparam logic [GAIN_WIDTH-1:0]     SAMPLE_PERIOD_RST = 16'd10;
  localparam logic [DUTY_LIM_WIDTH-1:0] DUTY_UPPER_RST    = 15'd21760;
  localparam logic [DUTY_LIM_WIDTH-1:0] DUTY_LOWER_RST    = 15'd3840;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]     prop_gain;
    logic [GAIN_WIDTH-1:0]     integral_gain;
    logic [GAIN_WIDTH-1:0]     sample_period;
    logic [DUTY_LIM_WIDTH-1:0] duty_upper;
    logic [DUTY_LIM_WIDTH-1:0] duty_lower;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_INTEG,
    ST_MUL_K,
    ST_SUM,
    ST_LIMIT,
    ST_CLEAR
  } state_t;

  typedef enum logic [1:0] {
    MUL_PROP,
    MUL_STEP,
    MUL_INTEG
  } mul_sel_t;

  typedef struct packed {
    logic     load_err;
    logic     int_clear;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     term_p_load;
    logic     int_update;
    logic     sum_load;
    logic     out_load;
    logic     out_zero;
  } dp_cmd_t;

endpackage

@@ sv/speed_pi_controller_q22_10.sv @@
// Top level of the Q22.10 PI speed controller with a Q8.8 duty limiter.
//
//   Channel   Signals                                          Direction
//   input     in_valid, in_ready, action, speed_target,        transaction in
//             speed_measured
//   output    out_valid, out_ready, duty_out, was_clamped      transaction out
//   config    psel, penable, pwrite, paddr, pwdata, prdata,    register access
//             pready
//
// A control step passes through the states MUL_P, MUL_I, INTEG, MUL_K, SUM and LIMIT:
// three products pass one after another through the single registered multiplier, with
// an integrator update between the second and third and a final sum after them. A clear
// transaction passes through the CLEAR state and then loads a zero result.
// The next transaction is accepted once the result is in the output register.
// Reset is synchronous and clears the integrator, the state and the output flag.
// If the previous result has not been taken, a step holds in its limiter state and a clear in its clear state.
`timescale 1ns / 1ps
`include "speed_pi_controller_q22_10_defines.svh"
module speed_pi_controller_q22_10 (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   action,
  input  logic signed [spc_pkg::SPEED_WIDTH-1:0] speed_target,
  input  logic signed [spc_pkg::SPEED_WIDTH-1:0] speed_measured,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [spc_pkg::DUTY_WIDTH-1:0]  duty_out,
  output logic                                   was_clamped,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [spc_pkg::ADDR_WIDTH-1:0]         paddr,
  input  logic [spc_pkg::DATA_WIDTH-1:0]         pwdata,
  output logic [spc_pkg::DATA_WIDTH-1:0]         prdata,
  output logic                                   pready
);

  spc_pkg::cfg_t    cfg;
  spc_pkg::dp_cmd_t cmd;

  spc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .speed_target   (speed_target),
    .speed_measured (speed_measured),
    .duty_out       (duty_out),
    .was_clamped    (was_clamped)
  );

  // A new result never overwrites one that is still waiting.
  `SPC_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, (!out_valid || out_ready))
  // Only one transaction is in flight at a time.
  `SPC_ASSERT_NEXT(a_one_in_flight, clk, rst, (in_valid && in_ready), !in_ready)
  // A clear transaction always delivers a zero, unclamped duty.
  `SPC_ASSERT_NEXT(a_clear_zero, clk, rst, (cmd.out_load && cmd.out_zero), (out_valid && duty_out == 0 && !was_clamped))

endmodule

@@ sv/spc_regs.sv @@
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
module spc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spc_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [spc_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [spc_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                            pready,
  output spc_pkg::cfg_t                   cfg
);

  logic                wr_en;
  spc_pkg::reg_idx_t   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = spc_pkg::reg_idx_t'(paddr[spc_pkg::ADDR_WIDTH-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= spc_pkg::PROP_GAIN_RST;
      cfg.integral_gain <= spc_pkg::INTEGRAL_GAIN_RST;
      cfg.sample_period <= spc_pkg::SAMPLE_PERIOD_RST;
      cfg.duty_upper    <= spc_pkg::DUTY_UPPER_RST;
      cfg.duty_lower    <= spc_pkg::DUTY_LOWER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        spc_pkg::REG_PROP_GAIN:
          cfg.prop_gain <= pwdata[spc_pkg::GAIN_WIDTH-1:0];
        spc_pkg::REG_INTEGRAL_GAIN:
          cfg.integral_gain <= pwdata[spc_pkg::GAIN_WIDTH-1:0];
        spc_pkg::REG_SAMPLE_PERIOD:
          cfg.sample_period <= pwdata[spc_pkg::GAIN_WIDTH-1:0];
        spc_pkg::REG_DUTY_UPPER:
          cfg.duty_upper <= pwdata[spc_pkg::DUTY_LIM_WIDTH-1:0];
        spc_pkg::REG_DUTY_LOWER:
          cfg.duty_lower <= pwdata[spc_pkg::DUTY_LIM_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      spc_pkg::REG_PROP_GAIN:
        prdata = spc_pkg::DATA_WIDTH'(cfg.prop_gain);
      spc_pkg::REG_INTEGRAL_GAIN:
        prdata = spc_pkg::DATA_WIDTH'(cfg.integral_gain);
      spc_pkg::REG_SAMPLE_PERIOD:
        prdata = spc_pkg::DATA_WIDTH'(cfg.sample_period);
      spc_pkg::REG_DUTY_UPPER:
        prdata = spc_pkg::DATA_WIDTH'(cfg.duty_upper);
      spc_pkg::REG_DUTY_LOWER:
        prdata = spc_pkg::DATA_WIDTH'(cfg.duty_lower);
      default: prdata = '0;
    endcase
  end

endmodule

@@ sv/spc_datapath.sv @@
// Datapath: error, shared multiplier, integrator, sum and duty limiter.
`timescale 1ns / 1ps
module spc_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  spc_pkg::dp_cmd_t                      cmd,
  input  spc_pkg::cfg_t                         cfg,
  input  logic signed [spc_pkg::SPEED_WIDTH-1:0] speed_target,
  input  logic signed [spc_pkg::SPEED_WIDTH-1:0] speed_measured,
  output logic signed [spc_pkg::DUTY_WIDTH-1:0]  duty_out,
  output logic                                  was_clamped
);

  localparam int AW = spc_pkg::ACC_WIDTH;
  localparam int LW = spc_pkg::DUTY_WIDTH + 1;

  logic        [spc_pkg::ERR_WIDTH-1:0]  err;
  logic        [AW-1:0]                  eq;
  logic        [AW-1:0]                  integ;
  logic        [AW-1:0]                  term_p;
  logic        [AW-1:0]                  sum;
  logic signed [spc_pkg::PROD_WIDTH-1:0] prod;
  logic        [AW-1:0]                  prod_q;
  logic signed [AW-1:0]                  mul_a;
  logic        [spc_pkg::GAIN_WIDTH-1:0] mul_g;

  logic signed [spc_pkg::DUTY_WIDTH-1:0] d;
  logic signed [LW-1:0]                  d_ext;
  logic signed [LW-1:0]                  hi;
  logic signed [LW-1:0]                  lo;
  logic signed [LW-1:0]                  lim;

  assign err = {speed_target[spc_pkg::SPEED_WIDTH-1], speed_target}
             - {speed_measured[spc_pkg::SPEED_WIDTH-1], speed_measured};

  // Arithmetic shift right by the fraction width, keeping the accumulator width.
  assign prod_q = prod[AW+spc_pkg::FRAC_BITS-1:spc_pkg::FRAC_BITS];

  always_comb begin
    mul_a = eq;
    mul_g = cfg.prop_gain;
    case (cmd.mul_sel)
      spc_pkg::MUL_PROP: begin
        mul_a = eq;
        mul_g = cfg.prop_gain;
      end
      spc_pkg::MUL_STEP: begin
        mul_a = eq;
        mul_g = cfg.sample_period;
      end
      spc_pkg::MUL_INTEG: begin
        mul_a = integ;
        mul_g = cfg.integral_gain;
      end
      default: begin
        mul_a = eq;
        mul_g = cfg.prop_gain;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      eq <= {{(AW-spc_pkg::ERR_WIDTH){err[spc_pkg::ERR_WIDTH-1]}}, err} << spc_pkg::FRAC_BITS;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * $signed({1'b0, mul_g});
    end
    if (cmd.term_p_load) begin
      term_p <= prod_q;
    end
    if (cmd.sum_load) begin
      sum <= term_p + prod_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (cmd.int_clear) begin
      integ <= '0;
    end else if (cmd.int_update) begin
      integ <= integ + prod_q;
    end
  end

  // Deadband limiter on the Q8.8 value; the upper bound is tested first.
  always_comb begin
    d     = sum[spc_pkg::DUTY_WIDTH+spc_pkg::DUTY_SHIFT-1:spc_pkg::DUTY_SHIFT];
    d_ext = LW'(d);
    hi    = $signed(LW'(cfg.duty_upper));
    lo    = $signed(LW'(cfg.duty_lower));
    lim   = d_ext;
    if (d_ext > 0) begin
      if (d_ext > hi) begin
        lim = hi;
      end else if (d_ext < lo) begin
        lim = lo;
      end
    end else if (d_ext < 0) begin
      if (d_ext < -hi) begin
        lim = -hi;
      end else if (d_ext > -lo) begin
        lim = -lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_zero) begin
        duty_out    <= '0;
        was_clamped <= 1'b0;
      end else begin
        duty_out    <= lim[spc_pkg::DUTY_WIDTH-1:0];
        was_clamped <= (lim != d_ext);
      end
    end
  end

endmodule

@@ sv/spc_ctrl.sv @@
// Controller state machine that sequences one controller step or one clear and holds the result flag.
`timescale 1ns / 1ps
module spc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             action,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output spc_pkg::dp_cmd_t cmd
);

  spc_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = spc_pkg::MUL_PROP;
    unique case (state)
      spc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_err = 1'b1;
          if (action) begin
            cmd.int_clear = 1'b1;
            state_next    = spc_pkg::ST_CLEAR;
          end else begin
            state_next = spc_pkg::ST_MUL_P;
          end
        end
      end
      spc_pkg::ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = spc_pkg::MUL_PROP;
        state_next  = spc_pkg::ST_MUL_I;
      end
      spc_pkg::ST_MUL_I: begin
        cmd.term_p_load = 1'b1;
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = spc_pkg::MUL_STEP;
        state_next      = spc_pkg::ST_INTEG;
      end
      spc_pkg::ST_INTEG: begin
        cmd.int_update = 1'b1;
        state_next     = spc_pkg::ST_MUL_K;
      end
      spc_pkg::ST_MUL_K: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = spc_pkg::MUL_INTEG;
        state_next  = spc_pkg::ST_SUM;
      end
      spc_pkg::ST_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = spc_pkg::ST_LIMIT;
      end
      spc_pkg::ST_LIMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = spc_pkg::ST_IDLE;
        end
      end
      spc_pkg::ST_CLEAR: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = 1'b1;
          state_next   = spc_pkg::ST_IDLE;
        end
      end
      default: state_next = spc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule
